// ===== rtl/core/bamx_pkg.sv =====
`default_nettype none

package bamx_pkg;

    localparam int GRID_SIZE       = 8;
    localparam int BRIGHTNESS_BITS = 4;

    localparam int COORD_W     = 3;
    localparam int LEVEL_W     = 4;
    localparam int DATA_W      = 8;
    localparam int COLOUR_W    = 2;
    localparam int PLANE_OUT_W = 2;
    localparam int NUM_COLOURS = 3;

    localparam int IDX_W     = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
    localparam int PLANE_W   = (BRIGHTNESS_BITS > 1) ? $clog2(BRIGHTNESS_BITS) : 1;
    localparam int CELL_W    = NUM_COLOURS * BRIGHTNESS_BITS;
    localparam int BIT_SEL_W = $clog2(CELL_W);
    localparam int RAM_DEPTH = GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);

    localparam int PERIOD_TICKS = GRID_SIZE * ((1 << BRIGHTNESS_BITS) - 1);
    localparam int TICK_W       = $clog2(PERIOD_TICKS + 1);

    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 2);

    localparam logic REQ_TICK = 1'b1;

    localparam logic [COLOUR_W-1:0] COLOUR_RED   = 2'd0;
    localparam logic [COLOUR_W-1:0] COLOUR_GREEN = 2'd1;
    localparam logic [COLOUR_W-1:0] COLOUR_BLUE  = 2'd2;

    typedef enum logic [1:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN
    } scan_state_t;

    typedef struct packed
    {
        logic                       is_tick;
        logic [IDX_W-1:0]           layer;
        logic [IDX_W-1:0]           row;
        logic [IDX_W-1:0]           column;
        logic [BRIGHTNESS_BITS-1:0] red;
        logic [BRIGHTNESS_BITS-1:0] green;
        logic [BRIGHTNESS_BITS-1:0] blue;
    } cmd_t;

    typedef struct packed
    {
        logic [COLOUR_W-1:0] colour;
        logic [IDX_W-1:0]    row;
        logic [IDX_W-1:0]    layer;
        logic [PLANE_W-1:0]  plane;
        logic                last;
    } beat_meta_t;

    typedef struct packed
    {
        logic [DATA_W-1:0] data;
        beat_meta_t        meta;
    } beat_t;

    function automatic logic [IDX_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
        logic [IDX_W-1:0] r;
        if (int'(v) >= GRID_SIZE)
        begin
            r = IDX_W'(GRID_SIZE - 1);
        end
        else
        begin
            r = IDX_W'(v);
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] layer,
                                                    input logic [IDX_W-1:0] row);
        return ADDR_W'(ADDR_W'(layer) * ADDR_W'(GRID_SIZE) + ADDR_W'(row));
    endfunction

    // tick count at which the given plane hands over to the next one
    function automatic logic [TICK_W-1:0] plane_end(input logic [PLANE_W-1:0] p);
        int n;
        n = GRID_SIZE * ((1 << (int'(p) + 1)) - 1);
        return TICK_W'(n);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bamx_ram.sv =====
`default_nettype none

module bamx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bamx_front.sv =====
`default_nettype none

module bamx_front import bamx_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               req_type,
    input  logic [COORD_W-1:0] layer_sel,
    input  logic [COORD_W-1:0] row_sel,
    input  logic [COORD_W-1:0] column_sel,
    input  logic [LEVEL_W-1:0] red_level,
    input  logic [LEVEL_W-1:0] green_level,
    input  logic [LEVEL_W-1:0] blue_level,
    input  logic               clearing,
    output logic               cmd_valid,
    output cmd_t               cmd,
    input  logic               cmd_pop
);

    cmd_t                 q_mem_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg, count_next;
    cmd_t                 decoded;
    logic                 push_ok;
    logic                 pop_ok;

    always_comb
    begin
        decoded.is_tick = (req_type == REQ_TICK);
        decoded.layer   = clamp_coord(layer_sel);
        decoded.row     = clamp_coord(row_sel);
        decoded.column  = clamp_coord(column_sel);
        decoded.red     = BRIGHTNESS_BITS'(red_level);
        decoded.green   = BRIGHTNESS_BITS'(green_level);
        decoded.blue    = BRIGHTNESS_BITS'(blue_level);
    end

    assign full      = (count_reg == CMD_CNT_W'(CMD_DEPTH)) || clearing;
    assign push_ok   = push && !full;
    assign cmd_valid = (count_reg != '0);
    assign pop_ok    = cmd_pop && cmd_valid;
    assign cmd       = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_mem_reg[wr_ptr_reg] <= decoded;
        end
    end

`ifndef SYNTHESIS
    a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("back end popped an empty request queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/bamx_back.sv =====
`default_nettype none

module bamx_back import bamx_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    input  cmd_t                   cmd,
    output logic                   cmd_pop,
    output logic                   clearing,
    output logic                   empty,
    input  logic                   pop,
    output logic [DATA_W-1:0]      data_byte,
    output logic [COLOUR_W-1:0]    colour,
    output logic [COORD_W-1:0]     row_index,
    output logic [COORD_W-1:0]     layer_index,
    output logic [PLANE_OUT_W-1:0] plane_index,
    output logic                   last
);

    scan_state_t          state_reg, state_next;
    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    logic [COLOUR_W-1:0]  seq_colour_reg, seq_colour_next;
    logic [IDX_W-1:0]     seq_row_reg, seq_row_next;
    logic [IDX_W-1:0]     layer_reg, layer_next;
    logic [PLANE_W-1:0]   plane_reg, plane_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic [TICK_W-1:0]    tick_inc;
    logic                 pend_reg;
    beat_meta_t           pend_meta_reg, pend_meta_next;

    beat_t                out_mem_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] out_wr_ptr_reg, out_rd_ptr_reg;
    logic [OUT_CNT_W-1:0] out_count_reg, out_count_next;
    logic [OUT_CNT_W-1:0] out_fill;
    logic                 out_pop_ok;
    beat_t                out_head;
    beat_t                out_beat;

    logic                 room;
    logic                 issue;
    logic                 issue_last;
    logic [GRID_SIZE-1:0] ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [CELL_W-1:0]    ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [CELL_W-1:0]    ram_rd [GRID_SIZE];
    logic [BIT_SEL_W-1:0] bit_sel;
    logic [GRID_SIZE-1:0] row_bits;

    // one RAM per column: each word holds an LED's levels {blue, green, red}
    for (genvar gi = 0; gi < GRID_SIZE; gi++)
    begin : g_col
        bamx_ram #(
            .WIDTH (CELL_W),
            .DEPTH (RAM_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we[gi]),
            .waddr (ram_waddr),
            .wdata (ram_wdata),
            .raddr (ram_raddr),
            .rdata (ram_rd[gi])
        );
    end

    assign out_fill   = out_count_reg + OUT_CNT_W'(pend_reg);
    assign room       = (out_fill < OUT_CNT_W'(OUT_DEPTH));
    assign issue_last = (seq_colour_reg == COLOUR_BLUE) &&
                        (seq_row_reg == IDX_W'(GRID_SIZE - 1));
    assign ram_raddr  = cell_addr(layer_reg, seq_row_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(RAM_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid && cmd.is_tick)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (room && issue_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        clearing  = 1'b0;
        cmd_pop   = 1'b0;
        issue     = 1'b0;
        ram_we    = '0;
        ram_waddr = cell_addr(cmd.layer, cmd.row);
        ram_wdata = {cmd.blue, cmd.green, cmd.red};
        case (state_reg)
            ST_CLEAR:
            begin
                clearing  = 1'b1;
                ram_we    = '1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (!cmd.is_tick)
                    begin
                        ram_we = GRID_SIZE'(1) << cmd.column;
                    end
                end
            end
            ST_SCAN:
            begin
                issue = room;
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        clr_addr_next   = clr_addr_reg;
        seq_colour_next = seq_colour_reg;
        seq_row_next    = seq_row_reg;
        layer_next      = layer_reg;
        plane_next      = plane_reg;
        tick_next       = tick_reg;
        tick_inc        = tick_reg + 1'b1;

        if (state_reg == ST_CLEAR)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
        end

        if (state_reg == ST_IDLE)
        begin
            seq_colour_next = COLOUR_RED;
            seq_row_next    = '0;
        end
        else if (issue)
        begin
            if (seq_row_reg == IDX_W'(GRID_SIZE - 1))
            begin
                seq_row_next = '0;
                case (seq_colour_reg)
                    COLOUR_RED:   seq_colour_next = COLOUR_GREEN;
                    COLOUR_GREEN: seq_colour_next = COLOUR_BLUE;
                    default:      seq_colour_next = COLOUR_RED;
                endcase
            end
            else
            begin
                seq_row_next = seq_row_reg + 1'b1;
            end
        end

        // counters move on once the burst's last read is out
        if (issue && issue_last)
        begin
            if (int'(tick_inc) >= PERIOD_TICKS)
            begin
                tick_next  = '0;
                plane_next = '0;
            end
            else
            begin
                tick_next = tick_inc;
                if ((int'(plane_reg) + 1 < BRIGHTNESS_BITS) &&
                    (tick_inc == plane_end(plane_reg)))
                begin
                    plane_next = plane_reg + 1'b1;
                end
            end
            if (int'(layer_reg) + 1 >= GRID_SIZE)
            begin
                layer_next = '0;
            end
            else
            begin
                layer_next = layer_reg + 1'b1;
            end
        end

        pend_meta_next.colour = seq_colour_reg;
        pend_meta_next.row    = seq_row_reg;
        pend_meta_next.layer  = layer_reg;
        pend_meta_next.plane  = plane_reg;
        pend_meta_next.last   = issue_last;
    end

    always_comb
    begin
        bit_sel = BIT_SEL_W'(BIT_SEL_W'(pend_meta_reg.colour) * BIT_SEL_W'(BRIGHTNESS_BITS)
                             + BIT_SEL_W'(pend_meta_reg.plane));
        for (int i = 0; i < GRID_SIZE; i++)
        begin
            row_bits[i] = ram_rd[i][bit_sel];
        end
        out_beat.data = DATA_W'(row_bits);
        out_beat.meta = pend_meta_reg;
    end

    assign out_pop_ok = pop && !empty;
    assign empty      = (out_count_reg == '0);
    assign out_head   = out_mem_reg[out_rd_ptr_reg];

    always_comb
    begin
        out_count_next = out_count_reg;
        if (pend_reg && !out_pop_ok)
        begin
            out_count_next = out_count_reg + 1'b1;
        end
        else if (out_pop_ok && !pend_reg)
        begin
            out_count_next = out_count_reg - 1'b1;
        end
    end

    assign data_byte   = out_head.data;
    assign colour      = out_head.meta.colour;
    assign row_index   = COORD_W'(out_head.meta.row);
    assign layer_index = COORD_W'(out_head.meta.layer);
    assign plane_index = PLANE_OUT_W'(out_head.meta.plane);
    assign last        = out_head.meta.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            seq_colour_reg <= COLOUR_RED;
            seq_row_reg    <= '0;
            layer_reg      <= '0;
            plane_reg      <= '0;
            tick_reg       <= '0;
            pend_reg       <= 1'b0;
            out_wr_ptr_reg <= '0;
            out_rd_ptr_reg <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            seq_colour_reg <= seq_colour_next;
            seq_row_reg    <= seq_row_next;
            layer_reg      <= layer_next;
            plane_reg      <= plane_next;
            tick_reg       <= tick_next;
            pend_reg       <= issue;
            out_count_reg  <= out_count_next;
            if (pend_reg)
            begin
                out_wr_ptr_reg <= out_wr_ptr_reg + 1'b1;
            end
            if (out_pop_ok)
            begin
                out_rd_ptr_reg <= out_rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pend_meta_reg <= pend_meta_next;
        end
        if (pend_reg)
        begin
            out_mem_reg[out_wr_ptr_reg] <= out_beat;
        end
    end

`ifndef SYNTHESIS
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (out_count_reg < OUT_CNT_W'(OUT_DEPTH)))
        else $error("result queue overrun");

    a_quiet_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!cmd_pop && !issue))
        else $error("request served during clearing pass");

    a_burst_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && issue_last) |=> (state_reg == ST_IDLE) && pend_reg && pend_meta_reg.last)
        else $error("burst did not close after its last read");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/bam_rgb_led_matrix_scan.sv =====
// Bit angle modulation refresh engine for an 8x8x8 RGB LED array.
// Requests enter through a queue-style port: push/full, accepted when push
// is high and full is low. req_type 0 writes one LED's red, green and blue
// levels and gives no result. req_type 1 is a refresh tick: it sends 24
// bytes for the active layer and bit plane (red rows, then green, then
// blue; last marks the 24th) and then steps the layer and tick counters,
// moving to the next plane once the current plane's ticks are done.
// Results leave through empty/pop; the oldest byte is on the ports while
// empty is low and is taken when pop is high and empty is low.
// A taken tick puts the back end in its scan state; it then reads one row
// word per cycle from the per-column RAMs while the result queue has room,
// and each byte is registered before it enters the result queue. A short
// request queue lets further requests be taken while a burst is under way.
// When the receiver stalls, the 4-entry result queue fills and RAM reads
// pause; nothing is dropped.
// After reset a clearing pass zeroes every address of the LED store; full
// stays high during it. Layer, plane and tick counters reset to zero.
`default_nettype none

module bam_rgb_led_matrix_scan import bamx_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic                   req_type,
    input  logic [COORD_W-1:0]     layer_sel,
    input  logic [COORD_W-1:0]     row_sel,
    input  logic [COORD_W-1:0]     column_sel,
    input  logic [LEVEL_W-1:0]     red_level,
    input  logic [LEVEL_W-1:0]     green_level,
    input  logic [LEVEL_W-1:0]     blue_level,
    output logic                   empty,
    input  logic                   pop,
    output logic [DATA_W-1:0]      data_byte,
    output logic [COLOUR_W-1:0]    colour,
    output logic [COORD_W-1:0]     row_index,
    output logic [COORD_W-1:0]     layer_index,
    output logic [PLANE_OUT_W-1:0] plane_index,
    output logic                   last
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;
    logic clearing;

    bamx_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .layer_sel   (layer_sel),
        .row_sel     (row_sel),
        .column_sel  (column_sel),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .clearing    (clearing),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    bamx_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .clearing    (clearing),
        .empty       (empty),
        .pop         (pop),
        .data_byte   (data_byte),
        .colour      (colour),
        .row_index   (row_index),
        .layer_index (layer_index),
        .plane_index (plane_index),
        .last        (last)
    );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import bamx_pkg::*;

    localparam logic REQ_WRITE      = ~REQ_TICK;
    localparam int   RANDOM_REQS    = 500;
    localparam int   TICK_PERCENT   = 45;
    localparam int   MAX_GAP        = 4;
    localparam int   WATCHDOG_LIMIT = 2000;
    localparam int   DRAIN_CYCLES   = 60;

    typedef struct packed
    {
        logic                kind;
        logic [COORD_W-1:0]  layer;
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  column;
        logic [LEVEL_W-1:0]  red;
        logic [LEVEL_W-1:0]  green;
        logic [LEVEL_W-1:0]  blue;
    } led_req_t;

    typedef struct packed
    {
        logic [DATA_W-1:0]      data;
        logic [COLOUR_W-1:0]    colour;
        logic [COORD_W-1:0]     row;
        logic [COORD_W-1:0]     layer;
        logic [PLANE_OUT_W-1:0] plane;
        logic                   last;
    } scan_byte_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    logic                   req_type = 1'b0;
    logic [COORD_W-1:0]     layer_sel = '0;
    logic [COORD_W-1:0]     row_sel = '0;
    logic [COORD_W-1:0]     column_sel = '0;
    logic [LEVEL_W-1:0]     red_level = '0;
    logic [LEVEL_W-1:0]     green_level = '0;
    logic [LEVEL_W-1:0]     blue_level = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [DATA_W-1:0]      data_byte;
    logic [COLOUR_W-1:0]    colour;
    logic [COORD_W-1:0]     row_index;
    logic [COORD_W-1:0]     layer_index;
    logic [PLANE_OUT_W-1:0] plane_index;
    logic                   last;

    // LED store as seen by the scan: one row byte per layer, row and plane
    logic [DATA_W-1:0] red_rows   [GRID_SIZE][GRID_SIZE][BRIGHTNESS_BITS];
    logic [DATA_W-1:0] green_rows [GRID_SIZE][GRID_SIZE][BRIGHTNESS_BITS];
    logic [DATA_W-1:0] blue_rows  [GRID_SIZE][GRID_SIZE][BRIGHTNESS_BITS];
    int                scan_layer = 0;
    int                scan_ticks = 0;
    int                scan_plane = 0;

    led_req_t   req_pending [$];
    scan_byte_t bytes_due [$];

    logic push_hit = 1'b0;
    logic pop_hit = 1'b0;
    int   push_gap = 0;
    int   pop_gap = 0;
    logic push_calm = 1'b0;
    logic pop_calm = 1'b0;
    int   idle_cycles = 0;
    int   mismatches = 0;

    bam_rgb_led_matrix_scan u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .layer_sel   (layer_sel),
        .row_sel     (row_sel),
        .column_sel  (column_sel),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .empty       (empty),
        .pop         (pop),
        .data_byte   (data_byte),
        .colour      (colour),
        .row_index   (row_index),
        .layer_index (layer_index),
        .plane_index (plane_index),
        .last        (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int fit_coord(input logic [COORD_W-1:0] v);
        return (int'(v) >= GRID_SIZE) ? GRID_SIZE - 1 : int'(v);
    endfunction

    function automatic logic level_bit(input logic [LEVEL_W-1:0] lvl, input int b);
        return (b < LEVEL_W) ? lvl[b] : 1'b0;
    endfunction

    // updates the LED store or queues the 24 bytes of a refresh burst
    function automatic void apply_led_request(input led_req_t rq);
        int                lay;
        int                rw;
        int                col;
        int                b;
        int                c;
        scan_byte_t        sb;
        if (rq.kind == REQ_WRITE)
        begin
            lay = fit_coord(rq.layer);
            rw  = fit_coord(rq.row);
            col = fit_coord(rq.column);
            for (b = 0; b < BRIGHTNESS_BITS; b++)
            begin
                red_rows[lay][rw][b][col]   = level_bit(rq.red, b);
                green_rows[lay][rw][b][col] = level_bit(rq.green, b);
                blue_rows[lay][rw][b][col]  = level_bit(rq.blue, b);
            end
        end
        else
        begin
            for (c = 0; c < NUM_COLOURS; c++)
            begin
                for (rw = 0; rw < GRID_SIZE; rw++)
                begin
                    sb.colour = COLOUR_W'(c);
                    case (sb.colour)
                        COLOUR_RED:   sb.data = red_rows[scan_layer][rw][scan_plane];
                        COLOUR_GREEN: sb.data = green_rows[scan_layer][rw][scan_plane];
                        default:      sb.data = blue_rows[scan_layer][rw][scan_plane];
                    endcase
                    sb.row   = COORD_W'(rw);
                    sb.layer = COORD_W'(scan_layer);
                    sb.plane = PLANE_OUT_W'(scan_plane);
                    sb.last  = (c == NUM_COLOURS - 1) && (rw == GRID_SIZE - 1);
                    bytes_due.push_back(sb);
                end
            end
            // plane k is held for GRID_SIZE * 2^k ticks of the period
            scan_ticks++;
            if (scan_ticks >= PERIOD_TICKS)
            begin
                scan_ticks = 0;
                scan_plane = 0;
            end
            else if (scan_plane + 1 < BRIGHTNESS_BITS &&
                     scan_ticks == GRID_SIZE * ((1 << (scan_plane + 1)) - 1))
            begin
                scan_plane++;
            end
            scan_layer = (scan_layer + 1) % GRID_SIZE;
        end
    endfunction

    task automatic queue_write(input int l, input int r, input int c,
                               input int rl, input int gl, input int bl);
        led_req_t rq;
        rq.kind   = REQ_WRITE;
        rq.layer  = COORD_W'(l);
        rq.row    = COORD_W'(r);
        rq.column = COORD_W'(c);
        rq.red    = LEVEL_W'(rl);
        rq.green  = LEVEL_W'(gl);
        rq.blue   = LEVEL_W'(bl);
        req_pending.push_back(rq);
    endtask

    task automatic queue_tick(input logic junk_high);
        led_req_t rq;
        rq        = junk_high ? '1 : '0;
        rq.kind   = REQ_TICK;
        req_pending.push_back(rq);
    endtask

    // request driver
    always @(negedge clk)
    begin
        led_req_t rq;
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else if (push && !push_hit)
        begin
            push <= 1'b1;
        end
        else if (push_gap > 0)
        begin
            push <= 1'b0;
            push_gap = push_gap - 1;
        end
        else if (req_pending.size() > 0)
        begin
            rq = req_pending.pop_front();
            req_type    <= rq.kind;
            layer_sel   <= rq.layer;
            row_sel     <= rq.row;
            column_sel  <= rq.column;
            red_level   <= rq.red;
            green_level <= rq.green;
            blue_level  <= rq.blue;
            push        <= 1'b1;
            if ($urandom_range(0, 31) == 0)
            begin
                push_calm = !push_calm;
            end
            push_gap = push_calm ? 0 : $urandom_range(0, MAX_GAP);
        end
        else
        begin
            push <= 1'b0;
        end
    end

    // result consumer
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (pop && !pop_hit)
        begin
            pop <= 1'b1;
        end
        else if (pop_gap > 0)
        begin
            pop <= 1'b0;
            pop_gap = pop_gap - 1;
        end
        else
        begin
            pop <= 1'b1;
            if ($urandom_range(0, 31) == 0)
            begin
                pop_calm = !pop_calm;
            end
            pop_gap = pop_calm ? 0 : $urandom_range(0, MAX_GAP);
        end
    end

    // monitor, prediction and watchdog
    always @(posedge clk)
    begin
        scan_byte_t seen;
        scan_byte_t want;
        if (!rst_n)
        begin
            push_hit    <= 1'b0;
            pop_hit     <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            push_hit <= push && !full;
            pop_hit  <= pop && !empty;
            if (pop && !empty)
            begin
                seen = {data_byte, colour, row_index, layer_index, plane_index, last};
                if (bytes_due.size() == 0)
                begin
                    $display("%0t: unexpected byte data %h colour %0d row %0d layer %0d plane %0d last %0d",
                             $time, seen.data, seen.colour, seen.row, seen.layer, seen.plane,
                             seen.last);
                    mismatches++;
                end
                else
                begin
                    want = bytes_due.pop_front();
                    if (seen !== want)
                    begin
                        $display("%0t: mismatch expected data %h colour %0d row %0d layer %0d plane %0d last %0d",
                                 $time, want.data, want.colour, want.row, want.layer, want.plane,
                                 want.last);
                        $display("%0t:            actual data %h colour %0d row %0d layer %0d plane %0d last %0d",
                                 $time, seen.data, seen.colour, seen.row, seen.layer, seen.plane,
                                 seen.last);
                        mismatches++;
                    end
                end
            end
            if (push && !full)
            begin
                apply_led_request({req_type, layer_sel, row_sel, column_sel,
                                   red_level, green_level, blue_level});
            end
            if ((push && !full) || (pop && !empty))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired at %0t", $time);
                $display("DONE: errors detected");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        led_req_t rq;
        int       i;
        int       l;
        int       r;
        int       b;
        for (l = 0; l < GRID_SIZE; l++)
        begin
            for (r = 0; r < GRID_SIZE; r++)
            begin
                for (b = 0; b < BRIGHTNESS_BITS; b++)
                begin
                    red_rows[l][r][b]   = '0;
                    green_rows[l][r][b] = '0;
                    blue_rows[l][r][b]  = '0;
                end
            end
        end

        // blank store first, then corners and mixed levels on layers 1 and 2
        queue_tick(1'b0);
        queue_write(1, 0, 0, 15, 15, 15);
        queue_write(1, 7, 7, 15, 15, 15);
        queue_write(1, 3, 5, 4'hA, 4'h5, 4'h9);
        queue_write(1, 7, 0, 4'h1, 4'h2, 4'h8);
        queue_tick(1'b1);
        queue_write(2, 0, 7, 15, 0, 0);
        queue_write(2, 7, 0, 0, 15, 0);
        queue_write(2, 4, 4, 0, 0, 15);
        queue_tick(1'b0);
        queue_write(1, 0, 0, 0, 0, 0);
        queue_write(1, 7, 7, 4'h6, 4'h3, 4'hC);
        for (i = 0; i < 8; i++)
        begin
            queue_tick(i[0]);
        end

        for (i = 0; i < RANDOM_REQS; i++)
        begin
            rq.kind   = ($urandom_range(0, 99) < TICK_PERCENT) ? REQ_TICK : REQ_WRITE;
            rq.layer  = COORD_W'($urandom_range(0, 7));
            rq.row    = COORD_W'($urandom_range(0, 7));
            rq.column = COORD_W'($urandom_range(0, 7));
            rq.red    = LEVEL_W'($urandom_range(0, 15));
            rq.green  = LEVEL_W'($urandom_range(0, 15));
            rq.blue   = LEVEL_W'($urandom_range(0, 15));
            req_pending.push_back(rq);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (req_pending.size() != 0 || push)
        begin
            @(posedge clk);
        end
        while (bytes_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
